### rtl/jsv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsv_pkg: shared types and constants of the JSON syntax validator
// Payload structs, parse modes, status and error codes.
// ----------------------------------------------------------------------------
package jsv_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] error_code;
  } out_item_t;

  typedef enum logic [4:0] {
    M_TOP_VALUE = 5'd0,  M_ARR_FIRST = 5'd1,  M_ARR_NEXT = 5'd2,
    M_OBJ_VALUE = 5'd3,  M_OBJ_FIRST = 5'd4,  M_OBJ_COMMA = 5'd5,
    M_OBJ_KEY = 5'd6,    M_OBJ_COLON = 5'd7,  M_ARR_AFTER = 5'd8,
    M_OBJ_AFTER = 5'd9,  M_TOP_AFTER = 5'd10, M_STR = 5'd11,
    M_STR_ESC = 5'd12,   M_STR_HEX = 5'd13,   M_KEY = 5'd14,
    M_KEY_ESC = 5'd15,   M_KEY_HEX = 5'd16,   M_LIT_TRUE = 5'd17,
    M_LIT_FALSE = 5'd18, M_LIT_NULL = 5'd19,  M_NUM_SIGN = 5'd20,
    M_NUM_ZERO = 5'd21,  M_NUM_INT = 5'd22,   M_NUM_DOT = 5'd23,
    M_NUM_FRAC = 5'd24,  M_NUM_E = 5'd25,     M_NUM_ESIGN = 5'd26,
    M_NUM_EXP = 5'd27
  } mode_t;

  localparam logic [1:0] ST_PENDING   = 2'd0;
  localparam logic [1:0] ST_ACCEPTED  = 2'd1;
  localparam logic [1:0] ST_REJECTED  = 2'd2;
  localparam logic [1:0] ST_DISCARDED = 2'd3;

  localparam logic [4:0] E_NONE      = 5'd0;
  localparam logic [4:0] E_END       = 5'd1;
  localparam logic [4:0] E_CHAR      = 5'd2;
  localparam logic [4:0] E_TOKEN     = 5'd3;
  localparam logic [4:0] E_DEPTH     = 5'd4;
  localparam logic [4:0] E_STR_END   = 5'd5;
  localparam logic [4:0] E_STR_CTRL  = 5'd6;
  localparam logic [4:0] E_ESC_END   = 5'd7;
  localparam logic [4:0] E_ESC_BAD   = 5'd8;
  localparam logic [4:0] E_HEX_SHORT = 5'd9;
  localparam logic [4:0] E_HEX_BAD   = 5'd10;
  localparam logic [4:0] E_NUM       = 5'd11;
  localparam logic [4:0] E_NUM_FRAC  = 5'd12;
  localparam logic [4:0] E_NUM_EXP   = 5'd13;
  localparam logic [4:0] E_ARR_SEP   = 5'd14;
  localparam logic [4:0] E_ARR_END   = 5'd15;
  localparam logic [4:0] E_OBJ_KEY   = 5'd16;
  localparam logic [4:0] E_OBJ_COLON = 5'd17;
  localparam logic [4:0] E_OBJ_SEP   = 5'd18;
  localparam logic [4:0] E_OBJ_END   = 5'd19;
  localparam logic [4:0] E_TRAILING  = 5'd20;

  localparam logic [10:0] MAX_NESTING_RESET = 11'd1024;
  localparam logic [7:0]  CTRL_LIMIT = 8'h20;

  // byte class, computed by the front end
  typedef struct packed {
    logic blank;
    logic dig;
    logic hex;
    logic ctrl;
  } cls_t;

  typedef struct packed {
    logic [7:0] c;
    logic       last;
    cls_t       cls;
  } cmd_t;

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      2'd0: case (i) 3'd0: r = "t"; 3'd1: r = "r"; 3'd2: r = "u"; 3'd3: r = "e";
              default: r = 8'h00; endcase
      2'd1: case (i) 3'd0: r = "f"; 3'd1: r = "a"; 3'd2: r = "l"; 3'd3: r = "s";
              3'd4: r = "e"; default: r = 8'h00; endcase
      2'd2: case (i) 3'd0: r = "n"; 3'd1: r = "u"; 3'd2: r = "l"; 3'd3: r = "l";
              default: r = 8'h00; endcase
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == 2'd1) ? 3'd5 : 3'd4;
  endfunction

endpackage
`default_nettype wire

### rtl/jsv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsv_front: input stage
// Registers incoming bytes with their character class into a two-entry queue.
// ----------------------------------------------------------------------------
module jsv_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire jsv_pkg::in_item_t in_item,
  input  wire logic             push,
  output logic                  full,
  output jsv_pkg::cmd_t         cmd,
  output logic                  cmd_valid,
  input  wire logic             cmd_take
);

  jsv_pkg::cmd_t q [2];
  logic          rd_ptr, wr_ptr;
  logic [1:0]    count;
  jsv_pkg::cmd_t c_in;
  logic [7:0]    b;
  logic          wr, rd;

  always_comb begin
    b = in_item.text_byte;
    c_in.c = b;
    c_in.last = in_item.last;
    c_in.cls.blank = (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
    c_in.cls.dig = (b >= "0") && (b <= "9");
    c_in.cls.hex = c_in.cls.dig || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
    c_in.cls.ctrl = b < jsv_pkg::CTRL_LIMIT;
  end

  assign full = (count == 2'd2);
  assign wr = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign rd = cmd_take && cmd_valid;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) q[wr_ptr] <= c_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule
`default_nettype wire

### rtl/jsv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsv_back: parse engine
// One byte per cycle through the parse state machine unless the two-entry
// result queue is full; the stack top is kept in a register, the rest in memory.
// ----------------------------------------------------------------------------
module jsv_back #(
  parameter int MAX_NEST = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire jsv_pkg::cmd_t     cmd,
  input  wire logic              cmd_valid,
  output logic                   cmd_take,
  input  wire logic [10:0]       max_nesting,
  output jsv_pkg::out_item_t     res,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   busy
);

  localparam int LW = $clog2(MAX_NEST + 2);
  localparam int AW = $clog2(MAX_NEST + 1);

  logic stack [MAX_NEST + 1];
  logic top_bit;            // stack[level-1], kept as a register
  logic prev_bit;           // stack[level-2], read from memory
  logic [AW-1:0] rd_addr;

  jsv_pkg::mode_t mode, mode_next;
  logic [LW-1:0]  level, level_next;
  logic [2:0]     lit_idx, lit_idx_next;
  logic [2:0]     hex_cnt, hex_cnt_next;
  logic           bad_hex, bad_hex_next;
  logic           err_l, err_l_next;
  logic           top_next;
  logic           push_en, push_val, pop_en;
  logic [LW-1:0]  limit;
  logic [1:0]     st;
  logic [4:0]     code;

  jsv_pkg::out_item_t oq [2];
  logic           o_rd, o_wr;
  logic [1:0]     o_cnt;
  logic           fire;

  assign limit = (max_nesting > 11'(MAX_NEST)) ? LW'(MAX_NEST) : LW'(max_nesting);
  assign fire = cmd_valid && (o_cnt != 2'd2);
  assign cmd_take = fire;
  assign empty = (o_cnt == 2'd0);
  assign res = oq[o_rd];
  assign busy = cmd_valid || !empty;

  // prev_bit holds stack[level-2]; its read address is formed from level_next
  assign rd_addr = (level_next >= LW'(2)) ? AW'(level_next - LW'(2)) : '0;

  always_comb begin
    logic [7:0] c;
    jsv_pkg::cls_t k;
    logic again, cont;
    logic [4:0] err;
    logic [1:0] lk;
    logic [2:0] h;
    logic top_eff;
    logic [LW-1:0] lvl;
    jsv_pkg::mode_t m;
    c = cmd.c;
    k = cmd.cls;
    again = 1'b0;
    err = jsv_pkg::E_NONE;
    m = mode;
    lvl = level;
    top_eff = top_bit;
    lit_idx_next = lit_idx;
    hex_cnt_next = hex_cnt;
    bad_hex_next = bad_hex;
    push_en = 1'b0;
    push_val = 1'b0;
    pop_en = 1'b0;
    lk = 2'd0;
    h = 3'd0;
    for (int pass = 0; pass < 2; pass++) begin
      cont = (pass == 0) || (again && err == jsv_pkg::E_NONE);
      if (cont) begin
        again = 1'b0;
        case (m)
          jsv_pkg::M_TOP_VALUE, jsv_pkg::M_OBJ_VALUE,
          jsv_pkg::M_ARR_FIRST, jsv_pkg::M_ARR_NEXT: begin
            if (k.blank) begin
            end else if (c == "]" && m == jsv_pkg::M_ARR_FIRST) begin
              pop_en = 1'b1;
              lvl = lvl - LW'(1);
              m = (lvl == '0) ? jsv_pkg::M_TOP_AFTER :
                  (prev_bit ? jsv_pkg::M_OBJ_AFTER : jsv_pkg::M_ARR_AFTER);
            end else if ((m == jsv_pkg::M_ARR_FIRST || m == jsv_pkg::M_ARR_NEXT)
                         && lvl > limit) begin
              err = jsv_pkg::E_DEPTH;
            end else if (c == "{" || c == "[") begin
              if (lvl > LW'(MAX_NEST)) err = jsv_pkg::E_DEPTH;
              else begin
                push_en = 1'b1;
                push_val = (c == "{");
                lvl = lvl + LW'(1);
                m = (c == "{") ? jsv_pkg::M_OBJ_FIRST : jsv_pkg::M_ARR_FIRST;
              end
            end else if (c == "\"") m = jsv_pkg::M_STR;
            else if (c == "t") begin m = jsv_pkg::M_LIT_TRUE; lit_idx_next = 3'd1; end
            else if (c == "f") begin m = jsv_pkg::M_LIT_FALSE; lit_idx_next = 3'd1; end
            else if (c == "n") begin m = jsv_pkg::M_LIT_NULL; lit_idx_next = 3'd1; end
            else if (c == "-") m = jsv_pkg::M_NUM_SIGN;
            else if (c == "0") m = jsv_pkg::M_NUM_ZERO;
            else if (k.dig) m = jsv_pkg::M_NUM_INT;
            else err = jsv_pkg::E_CHAR;
          end
          jsv_pkg::M_OBJ_FIRST, jsv_pkg::M_OBJ_KEY: begin
            if (k.blank) begin
            end else if (c == "}" && m == jsv_pkg::M_OBJ_FIRST) begin
              pop_en = 1'b1;
              lvl = lvl - LW'(1);
              m = (lvl == '0) ? jsv_pkg::M_TOP_AFTER :
                  (prev_bit ? jsv_pkg::M_OBJ_AFTER : jsv_pkg::M_ARR_AFTER);
            end else if (c == "\"") m = jsv_pkg::M_KEY;
            else err = jsv_pkg::E_OBJ_KEY;
          end
          jsv_pkg::M_OBJ_COMMA: begin
            if (k.blank) m = jsv_pkg::M_OBJ_KEY;
            else if (c == "\"") m = jsv_pkg::M_KEY;
            else err = jsv_pkg::E_OBJ_KEY;
          end
          jsv_pkg::M_OBJ_COLON: begin
            if (k.blank) begin
            end else if (c != ":") err = jsv_pkg::E_OBJ_COLON;
            else if (lvl > limit) err = jsv_pkg::E_DEPTH;
            else m = jsv_pkg::M_OBJ_VALUE;
          end
          jsv_pkg::M_ARR_AFTER, jsv_pkg::M_OBJ_AFTER: begin
            if (k.blank) begin
            end else if (c == ",") begin
              m = (m == jsv_pkg::M_ARR_AFTER) ? jsv_pkg::M_ARR_NEXT : jsv_pkg::M_OBJ_COMMA;
            end else if ((c == "]" && m == jsv_pkg::M_ARR_AFTER) ||
                         (c == "}" && m == jsv_pkg::M_OBJ_AFTER)) begin
              pop_en = 1'b1;
              lvl = lvl - LW'(1);
              m = (lvl == '0) ? jsv_pkg::M_TOP_AFTER :
                  (prev_bit ? jsv_pkg::M_OBJ_AFTER : jsv_pkg::M_ARR_AFTER);
            end else err = (m == jsv_pkg::M_ARR_AFTER) ? jsv_pkg::E_ARR_SEP
                                                       : jsv_pkg::E_OBJ_SEP;
          end
          jsv_pkg::M_TOP_AFTER: if (!k.blank) err = jsv_pkg::E_TRAILING;
          jsv_pkg::M_STR, jsv_pkg::M_KEY: begin
            if (c == "\"") begin
              if (m == jsv_pkg::M_KEY) m = jsv_pkg::M_OBJ_COLON;
              else m = (lvl == '0) ? jsv_pkg::M_TOP_AFTER :
                       (top_eff ? jsv_pkg::M_OBJ_AFTER : jsv_pkg::M_ARR_AFTER);
            end else if (c == "\\") begin
              m = (m == jsv_pkg::M_KEY) ? jsv_pkg::M_KEY_ESC : jsv_pkg::M_STR_ESC;
            end else if (k.ctrl) err = jsv_pkg::E_STR_CTRL;
          end
          jsv_pkg::M_STR_ESC, jsv_pkg::M_KEY_ESC: begin
            if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                c == "n" || c == "r" || c == "t") begin
              m = (m == jsv_pkg::M_KEY_ESC) ? jsv_pkg::M_KEY : jsv_pkg::M_STR;
            end else if (c == "u") begin
              m = (m == jsv_pkg::M_KEY_ESC) ? jsv_pkg::M_KEY_HEX : jsv_pkg::M_STR_HEX;
              hex_cnt_next = 3'd0;
              bad_hex_next = 1'b0;
            end else err = jsv_pkg::E_ESC_BAD;
          end
          jsv_pkg::M_STR_HEX, jsv_pkg::M_KEY_HEX: begin
            bad_hex_next = bad_hex || !k.hex;
            h = hex_cnt + 3'd1;
            hex_cnt_next = h;
            if (h >= 3'd4) begin
              hex_cnt_next = 3'd0;
              if (bad_hex_next) err = jsv_pkg::E_HEX_BAD;
              else m = (m == jsv_pkg::M_KEY_HEX) ? jsv_pkg::M_KEY : jsv_pkg::M_STR;
            end
          end
          jsv_pkg::M_LIT_TRUE, jsv_pkg::M_LIT_FALSE, jsv_pkg::M_LIT_NULL: begin
            lk = (m == jsv_pkg::M_LIT_TRUE) ? 2'd0 :
                 (m == jsv_pkg::M_LIT_FALSE) ? 2'd1 : 2'd2;
            if (lit_idx >= jsv_pkg::lit_len(lk) || c != jsv_pkg::lit_char(lk, lit_idx))
              err = jsv_pkg::E_TOKEN;
            else if (lit_idx + 3'd1 >= jsv_pkg::lit_len(lk)) begin
              lit_idx_next = 3'd0;
              m = (lvl == '0) ? jsv_pkg::M_TOP_AFTER :
                  (top_eff ? jsv_pkg::M_OBJ_AFTER : jsv_pkg::M_ARR_AFTER);
            end else lit_idx_next = lit_idx + 3'd1;
          end
          jsv_pkg::M_NUM_SIGN: begin
            if (!k.dig) err = jsv_pkg::E_NUM;
            else m = (c == "0") ? jsv_pkg::M_NUM_ZERO : jsv_pkg::M_NUM_INT;
          end
          jsv_pkg::M_NUM_DOT: begin
            if (!k.dig) err = jsv_pkg::E_NUM_FRAC;
            else m = jsv_pkg::M_NUM_FRAC;
          end
          jsv_pkg::M_NUM_E, jsv_pkg::M_NUM_ESIGN: begin
            if ((c == "+" || c == "-") && m == jsv_pkg::M_NUM_E) m = jsv_pkg::M_NUM_ESIGN;
            else if (!k.dig) err = jsv_pkg::E_NUM_EXP;
            else m = jsv_pkg::M_NUM_EXP;
          end
          jsv_pkg::M_NUM_INT, jsv_pkg::M_NUM_ZERO,
          jsv_pkg::M_NUM_FRAC, jsv_pkg::M_NUM_EXP: begin
            if (k.dig && m != jsv_pkg::M_NUM_ZERO) begin
            end else if (c == "." && (m == jsv_pkg::M_NUM_INT || m == jsv_pkg::M_NUM_ZERO))
              m = jsv_pkg::M_NUM_DOT;
            else if ((c == "e" || c == "E") && m != jsv_pkg::M_NUM_EXP)
              m = jsv_pkg::M_NUM_E;
            else begin
              m = (lvl == '0) ? jsv_pkg::M_TOP_AFTER :
                  (top_eff ? jsv_pkg::M_OBJ_AFTER : jsv_pkg::M_ARR_AFTER);
              again = 1'b1;
            end
          end
          default: begin
            m = jsv_pkg::M_TOP_VALUE;
            err = jsv_pkg::E_CHAR;
          end
        endcase
      end
    end

    if (err == jsv_pkg::E_NONE && cmd.last) begin
      if (m == jsv_pkg::M_NUM_ZERO || m == jsv_pkg::M_NUM_INT ||
          m == jsv_pkg::M_NUM_FRAC || m == jsv_pkg::M_NUM_EXP)
        m = (lvl == '0) ? jsv_pkg::M_TOP_AFTER :
            (top_eff ? jsv_pkg::M_OBJ_AFTER : jsv_pkg::M_ARR_AFTER);
      case (m)
        jsv_pkg::M_TOP_VALUE, jsv_pkg::M_OBJ_VALUE: err = jsv_pkg::E_END;
        jsv_pkg::M_ARR_FIRST, jsv_pkg::M_ARR_NEXT: err = jsv_pkg::E_ARR_END;
        jsv_pkg::M_OBJ_FIRST, jsv_pkg::M_OBJ_COMMA: err = jsv_pkg::E_OBJ_END;
        jsv_pkg::M_OBJ_KEY: err = jsv_pkg::E_OBJ_KEY;
        jsv_pkg::M_OBJ_COLON: err = jsv_pkg::E_OBJ_COLON;
        jsv_pkg::M_ARR_AFTER: err = jsv_pkg::E_ARR_SEP;
        jsv_pkg::M_OBJ_AFTER: err = jsv_pkg::E_OBJ_SEP;
        jsv_pkg::M_TOP_AFTER: err = jsv_pkg::E_NONE;
        jsv_pkg::M_STR, jsv_pkg::M_KEY: err = jsv_pkg::E_STR_END;
        jsv_pkg::M_STR_ESC, jsv_pkg::M_KEY_ESC: err = jsv_pkg::E_ESC_END;
        jsv_pkg::M_STR_HEX, jsv_pkg::M_KEY_HEX: err = jsv_pkg::E_HEX_SHORT;
        jsv_pkg::M_LIT_TRUE, jsv_pkg::M_LIT_FALSE, jsv_pkg::M_LIT_NULL:
          err = jsv_pkg::E_TOKEN;
        jsv_pkg::M_NUM_SIGN: err = jsv_pkg::E_NUM;
        jsv_pkg::M_NUM_DOT: err = jsv_pkg::E_NUM_FRAC;
        default: err = jsv_pkg::E_NUM_EXP;
      endcase
    end

    if (err_l) begin
      st = jsv_pkg::ST_DISCARDED;
      code = jsv_pkg::E_NONE;
    end else if (err != jsv_pkg::E_NONE) begin
      st = jsv_pkg::ST_REJECTED;
      code = err;
    end else begin
      st = cmd.last ? jsv_pkg::ST_ACCEPTED : jsv_pkg::ST_PENDING;
      code = jsv_pkg::E_NONE;
    end

    // state updates are frozen once an error is raised or latched, until a last byte clears the state
    if (err_l || err != jsv_pkg::E_NONE) begin
      mode_next = mode;
      level_next = level;
      lit_idx_next = lit_idx;
      hex_cnt_next = hex_cnt;
      bad_hex_next = (err == jsv_pkg::E_NONE || err_l) ? bad_hex : bad_hex_next;
      push_en = 1'b0;
      pop_en = 1'b0;
      err_l_next = 1'b1;
      top_next = top_bit;
    end else begin
      mode_next = m;
      level_next = lvl;
      err_l_next = err_l;
      top_next = push_en ? push_val : (pop_en ? prev_bit : top_bit);
    end
    if (!fire) begin
      mode_next = mode;
      level_next = level;
      lit_idx_next = lit_idx;
      hex_cnt_next = hex_cnt;
      bad_hex_next = bad_hex;
      err_l_next = err_l;
      top_next = top_bit;
      push_en = 1'b0;
      pop_en = 1'b0;
    end else if (cmd.last) begin
      mode_next = jsv_pkg::M_TOP_VALUE;
      level_next = '0;
      lit_idx_next = 3'd0;
      hex_cnt_next = 3'd0;
      bad_hex_next = 1'b0;
      err_l_next = 1'b0;
      push_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) stack[AW'(level)] <= push_val;
    prev_bit <= (push_en && level_next >= LW'(2) && AW'(level) == rd_addr) ? push_val
                : stack[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jsv_pkg::M_TOP_VALUE;
      level <= '0;
      lit_idx <= 3'd0;
      hex_cnt <= 3'd0;
      bad_hex <= 1'b0;
      err_l <= 1'b0;
      top_bit <= 1'b0;
    end else begin
      mode <= mode_next;
      level <= level_next;
      lit_idx <= lit_idx_next;
      hex_cnt <= hex_cnt_next;
      bad_hex <= bad_hex_next;
      err_l <= err_l_next;
      top_bit <= top_next;
    end
  end

  assign o_wr = 1'b0;

  always_ff @(posedge clk) begin
    if (fire) oq[o_rd ^ o_cnt[0]] <= '{status: st, error_code: code};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_rd <= 1'b0;
      o_cnt <= 2'd0;
    end else begin
      if (pop && !empty) o_rd <= ~o_rd;
      o_cnt <= o_cnt + {1'b0, fire} - {1'b0, (pop && !empty)} + {1'b0, o_wr};
    end
  end

endmodule
`default_nettype wire

### rtl/json_syntax_validator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_syntax_validator: streaming JSON syntax check
// Bytes of one document go in through a queue port (push/full); every byte
// produces one status/error result on the result queue port (empty/pop).
// A byte with last set ends the document; parse state then clears.
// A pushed byte is registered in the input queue, then its result in the
// result queue. Throughput: one byte per cycle while the result queue has
// room; the parse engine reads the container stack top from a register and
// the entry below it from the stack memory, addressed from the next level.
// Reset clears all control state and sets max_nesting to 1024; the stack
// memory is not cleared since only entries written in the current document
// are read. If pop stays low, the two-entry result queue fills, the engine
// stalls, its two-entry input queue fills and full rises.
// Register 0 (byte address 0): max_nesting, 11 bits, write while idle.
// ----------------------------------------------------------------------------
module json_syntax_validator #(
  parameter int MAX_NEST = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire jsv_pkg::in_item_t   in_item,
  input  wire logic                push,
  output logic                     full,
  output jsv_pkg::out_item_t       out_item,
  output logic                     empty,
  input  wire logic                pop,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [0:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  jsv_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_take, busy;
  logic [10:0]   max_nesting;

  assign pready = 1'b1;
  assign prdata = {21'd0, max_nesting};

  always_ff @(posedge clk) begin
    if (rst) max_nesting <= jsv_pkg::MAX_NESTING_RESET;
    else if (psel && penable && pwrite && paddr == 1'b0) max_nesting <= pwdata[10:0];
  end

  jsv_front u_front (
    .clk, .rst, .in_item, .push, .full,
    .cmd, .cmd_valid, .cmd_take
  );

  jsv_back #(.MAX_NEST(MAX_NEST)) u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_take, .max_nesting,
    .res(out_item), .empty, .pop, .busy
  );

`ifndef SYNTHESIS
  a_res_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_item.status == jsv_pkg::ST_REJECTED) == (out_item.error_code != 5'd0))
    else $error("error code without rejection");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result lost while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> busy)
    else $error("accepted byte not tracked");
`endif

endmodule
`default_nettype wire
